@@ src/svm_pkg.sv @@
`default_nettype none
package svm_pkg;

  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned MEM_AW      = $clog2(STORE_DEPTH);

  localparam int unsigned ADDR_W = 14;
  // Store index plus one bit of headroom before folding.
  localparam int unsigned POS_W  = 15;
  localparam int unsigned ELEM_W = 17;
  localparam int unsigned PROD_W = 35;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_PLAY   = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_SETPOS = 3'd3,
    ACT_MIX    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    REG_STEP   = 3'd0,
    REG_START  = 3'd1,
    REG_END    = 3'd2,
    REG_REPEAT = 3'd3,
    REG_MODE   = 3'd4,
    REG_VOLUME = 3'd5,
    REG_LVOL   = 3'd6,
    REG_RVOL   = 3'd7
  } reg_idx_e;

  localparam int unsigned MODE_LOOP   = 0;
  localparam int unsigned MODE_16BIT  = 1;
  localparam int unsigned MODE_STSRC  = 2;
  localparam int unsigned MODE_STOUT  = 3;
  localparam int unsigned MODE_INTERP = 4;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_EADDR = 13'h0002,
    S_EMOD  = 13'h0004,
    S_RDW   = 13'h0008,
    S_LMUL  = 13'h0010,
    S_LADD  = 13'h0020,
    S_AVG   = 13'h0040,
    S_SMUL  = 13'h0080,
    S_SADD  = 13'h0100,
    S_ADV   = 13'h0200,
    S_AMOD  = 13'h0400,
    S_FIN   = 13'h0800,
    S_SPARE = 13'h1000
  } state_e;

  typedef struct packed {
    logic              start;
    logic [POS_W-1:0]  dividend;
    logic [ADDR_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] rem;
  } rem_rsp_t;

endpackage
`default_nettype wire

@@ src/svm_rem.sv @@
`default_nettype none
module svm_rem (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  svm_pkg::rem_req_t    req_i,
  output svm_pkg::rem_rsp_t    rsp_o
);

  logic                        busy_q, done_q;
  logic [3:0]                  cnt_q;
  logic [svm_pkg::POS_W-1:0]   x_q;
  logic [svm_pkg::ADDR_W-1:0]  rem_q, div_q;
  logic [svm_pkg::POS_W-1:0]   trial;
  logic [svm_pkg::ADDR_W-1:0]  rem_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, x_q[svm_pkg::POS_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = svm_pkg::ADDR_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = svm_pkg::ADDR_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(svm_pkg::POS_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      x_q   <= x_q << 1;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

@@ src/sample_playback_voice_mixer_unit.sv @@
`default_nettype none
// Channel  | Handshake                          | Payload
// ---------+------------------------------------+------------------------------------
// config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
// input    | in_valid_i, in_ready_o             | action, sample_addr, sample_value,
//          |                                    | mix_in_left, mix_in_right
// output   | out_valid_o, out_ready_i           | mix_out_left/right, playing, position
//
// Non-mix items go from idle straight to the finish state. A mix item passes through an
// address and a read-wait state per store read, a multiply and an add state per interpolated
// channel and per scaled channel, and averaging, advance and finish states. Every read folded
// into the loop and a loop wrap at the end also wait on the bit-serial remainder unit.
// Reset clears control state; the store has no reset. The input is not ready while an item
// is in work; a finished result waits in the output register while the next item is taken.
module sample_playback_voice_mixer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [13:0]        sample_addr_i,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic signed [31:0] mix_in_left_i,
  input  wire logic signed [31:0] mix_in_right_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      mix_out_left_o,
  output logic signed [31:0]      mix_out_right_o,
  output logic                    playing_o,
  output logic [13:0]             play_position_o
);

  localparam int unsigned AW = svm_pkg::ADDR_W;
  localparam int unsigned PW = svm_pkg::POS_W;
  localparam int unsigned EW = svm_pkg::ELEM_W;
  localparam int unsigned MW = svm_pkg::PROD_W;

  // Configuration registers
  logic [23:0]  step_q;
  logic [AW-1:0] start_q, end_q, rep_q;
  logic [4:0]   mode_q;
  logic [9:0]   vol_q;
  logic [10:0]  lvol_q, rvol_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 24'd65536;
      start_q <= '0;
      end_q   <= 14'd16383;
      rep_q   <= '0;
      mode_q  <= '0;
      vol_q   <= 10'd256;
      lvol_q  <= 11'd256;
      rvol_q  <= 11'd256;
    end else if (cfg_wr) begin
      case (svm_pkg::reg_idx_e'(paddr[4:2]))
        svm_pkg::REG_STEP:   step_q  <= pwdata[23:0];
        svm_pkg::REG_START:  start_q <= pwdata[AW-1:0];
        svm_pkg::REG_END:    end_q   <= pwdata[AW-1:0];
        svm_pkg::REG_REPEAT: rep_q   <= pwdata[AW-1:0];
        svm_pkg::REG_MODE:   mode_q  <= pwdata[4:0];
        svm_pkg::REG_VOLUME: vol_q   <= pwdata[9:0];
        svm_pkg::REG_LVOL:   lvol_q  <= pwdata[10:0];
        svm_pkg::REG_RVOL:   rvol_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (svm_pkg::reg_idx_e'(paddr[4:2]))
      svm_pkg::REG_STEP:   prdata = {8'd0, step_q};
      svm_pkg::REG_START:  prdata = {18'd0, start_q};
      svm_pkg::REG_END:    prdata = {18'd0, end_q};
      svm_pkg::REG_REPEAT: prdata = {18'd0, rep_q};
      svm_pkg::REG_MODE:   prdata = {27'd0, mode_q};
      svm_pkg::REG_VOLUME: prdata = {22'd0, vol_q};
      svm_pkg::REG_LVOL:   prdata = {21'd0, lvol_q};
      svm_pkg::REG_RVOL:   prdata = {21'd0, rvol_q};
      default:             prdata = '0;
    endcase
  end

  // Voice state and sequencer
  svm_pkg::state_e state_q, state_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [AW-1:0]   play_q, play_d;
  logic [15:0]     frac_q, frac_d;
  logic            active_q, active_d;
  logic            out_valid_q, out_valid_d;

  logic signed [EW-1:0] e_q [4];
  logic signed [EW-1:0] e_d [4];
  logic signed [MW-1:0] prod_q, prod_d;
  logic signed [31:0]   mixl_q, mixl_d, mixr_q, mixr_d;
  logic signed [31:0]   outl_q, outr_q;
  logic                 outp_q;
  logic [AW-1:0]        outpos_q;
  logic                 load_out;

  logic [15:0] mem [svm_pkg::STORE_DEPTH];
  logic [15:0] rd_data_q;
  logic        rd_en, wr_en;
  logic [PW-1:0] rd_idx;

  svm_pkg::rem_req_t rem_req;
  svm_pkg::rem_rsp_t rem_rsp;

  svm_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  logic stereo, mode16, st_out, interp, loops;
  logic [1:0] n_last, ch_off, b_idx;
  logic       src_idx;
  logic [PW-1:0] elem_idx, pos, step_fr, carry_fr;
  logic          fold_need;
  logic [16:0]   frac_sum;
  logic [AW-1:0] loop_len, clamped, clamp_lo;
  logic signed [EW-1:0] a_sel, b_sel, s_sel, conv;
  logic signed [17:0]   diff, mul_a, avg_sum;
  logic signed [16:0]   mul_b;
  logic signed [MW-1:0] product, adj16, adj8;
  logic signed [31:0]   scaled;
  logic [10:0]          vol_sel;
  logic                 in_xfer;

  assign stereo   = mode_q[svm_pkg::MODE_STSRC];
  assign mode16   = mode_q[svm_pkg::MODE_16BIT];
  assign st_out   = mode_q[svm_pkg::MODE_STOUT];
  assign interp   = mode_q[svm_pkg::MODE_INTERP];
  assign loops    = mode_q[svm_pkg::MODE_LOOP] && (end_q > rep_q);
  assign loop_len = end_q - rep_q;
  assign n_last   = stereo ? (interp ? 2'd3 : 2'd1) : (interp ? 2'd1 : 2'd0);
  assign ch_off   = stereo ? 2'd2 : 2'd1;
  assign b_idx    = cnt_q + ch_off;
  assign src_idx  = stereo ? cnt_q[0] : 1'b0;

  assign elem_idx  = {1'b0, play_q} + {{(PW-2){1'b0}}, cnt_q};
  assign fold_need = (cnt_q != 2'd0) && (elem_idx >= {1'b0, end_q});

  assign frac_sum = {1'b0, frac_q} + {1'b0, step_q[15:0]};
  assign step_fr  = stereo ? {6'd0, step_q[23:16], 1'b0} : {7'd0, step_q[23:16]};
  assign carry_fr = frac_sum[16] ? (stereo ? 15'd2 : 15'd1) : 15'd0;
  assign pos      = {1'b0, play_q} + step_fr + carry_fr;

  // The lower clamp comes first, so an end below the start wins.
  assign clamp_lo = (sample_addr_i < start_q) ? start_q : sample_addr_i;
  assign clamped  = (clamp_lo > end_q) ? end_q : clamp_lo;

  // Eight-bit mode takes the signed low byte of the stored word.
  assign conv = mode16 ? EW'(signed'(rd_data_q)) : EW'(signed'(rd_data_q[7:0]));

  assign a_sel = e_q[cnt_q];
  assign b_sel = e_q[b_idx];
  assign s_sel = e_q[{1'b0, src_idx}];
  assign diff  = 18'(b_sel) - 18'(a_sel);
  assign vol_sel = (stereo || !st_out) ? {1'b0, vol_q} : (cnt_q[0] ? rvol_q : lvol_q);

  // The one multiplier serves both the interpolation and the volume steps.
  always_comb begin
    if (state_q == svm_pkg::S_LMUL) begin
      mul_a = diff;
      mul_b = {1'b0, frac_q};
    end else begin
      mul_a = 18'(s_sel);
      mul_b = {6'd0, vol_sel};
    end
  end
  assign product = MW'(mul_a) * MW'(mul_b);

  // Biasing negative values before the arithmetic shift truncates toward zero.
  assign adj16   = prod_q + (prod_q[MW-1] ? MW'(65535) : MW'(0));
  assign adj8    = prod_q + (prod_q[MW-1] ? MW'(255) : MW'(0));
  assign scaled  = mode16 ? 32'(adj8 >>> 8) : 32'(prod_q);
  assign avg_sum = 18'(e_q[0]) + 18'(e_q[1]);

  assign in_ready_o = (state_q == svm_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign wr_en      = in_xfer && (action_i == svm_pkg::ACT_WRITE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    play_d      = play_q;
    frac_d      = frac_q;
    active_d    = active_q;
    e_d         = e_q;
    prod_d      = prod_q;
    mixl_d      = mixl_q;
    mixr_d      = mixr_q;
    rd_en       = 1'b0;
    rd_idx      = elem_idx;
    rem_req     = '0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      svm_pkg::S_IDLE: begin
        if (in_xfer) begin
          mixl_d  = mix_in_left_i;
          mixr_d  = mix_in_right_i;
          state_d = svm_pkg::S_FIN;
          case (action_i)
            svm_pkg::ACT_PLAY: begin
              active_d = 1'b1;
              play_d   = start_q;
              frac_d   = '0;
            end
            svm_pkg::ACT_STOP: begin
              active_d = 1'b0;
              play_d   = '0;
            end
            svm_pkg::ACT_SETPOS: begin
              if (active_q) begin
                play_d = clamped;
              end
            end
            svm_pkg::ACT_MIX: begin
              if (active_q) begin
                cnt_d   = '0;
                state_d = svm_pkg::S_EADDR;
              end
            end
            default: ;
          endcase
        end
      end
      svm_pkg::S_EADDR: begin
        if (fold_need && loops) begin
          rem_req.start    = 1'b1;
          rem_req.dividend = elem_idx - {1'b0, rep_q};
          rem_req.divisor  = loop_len;
          state_d          = svm_pkg::S_EMOD;
        end else if (fold_need) begin
          // Neighbor past the end of a sound that does not loop reads as zero.
          e_d[cnt_q] = '0;
          if (cnt_q == n_last) begin
            cnt_d   = '0;
            state_d = interp ? svm_pkg::S_LMUL : svm_pkg::S_AVG;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = svm_pkg::S_RDW;
        end
      end
      svm_pkg::S_EMOD: begin
        rd_idx = {1'b0, rep_q} + {1'b0, rem_rsp.rem};
        if (rem_rsp.done) begin
          rd_en   = 1'b1;
          state_d = svm_pkg::S_RDW;
        end
      end
      svm_pkg::S_RDW: begin
        e_d[cnt_q] = conv;
        if (cnt_q == n_last) begin
          cnt_d   = '0;
          state_d = interp ? svm_pkg::S_LMUL : svm_pkg::S_AVG;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = svm_pkg::S_EADDR;
        end
      end
      svm_pkg::S_LMUL: begin
        prod_d  = product;
        state_d = svm_pkg::S_LADD;
      end
      svm_pkg::S_LADD: begin
        e_d[cnt_q] = a_sel + EW'(adj16 >>> 16);
        if (cnt_q[0] == stereo) begin
          cnt_d   = '0;
          state_d = svm_pkg::S_AVG;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = svm_pkg::S_LMUL;
        end
      end
      svm_pkg::S_AVG: begin
        if (stereo && !st_out) begin
          e_d[0] = EW'((avg_sum + 18'(avg_sum[17])) >>> 1);
        end
        cnt_d   = '0;
        state_d = svm_pkg::S_SMUL;
      end
      svm_pkg::S_SMUL: begin
        prod_d  = product;
        state_d = svm_pkg::S_SADD;
      end
      svm_pkg::S_SADD: begin
        if (cnt_q[0]) begin
          mixr_d = mixr_q + scaled;
        end else begin
          mixl_d = mixl_q + scaled;
        end
        if (cnt_q[0] == st_out) begin
          state_d = svm_pkg::S_ADV;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = svm_pkg::S_SMUL;
        end
      end
      svm_pkg::S_ADV: begin
        frac_d = frac_sum[15:0];
        if (pos >= {1'b0, end_q}) begin
          if (loops) begin
            rem_req.start    = 1'b1;
            rem_req.dividend = pos - {1'b0, rep_q};
            rem_req.divisor  = loop_len;
            state_d          = svm_pkg::S_AMOD;
          end else begin
            active_d = 1'b0;
            play_d   = '0;
            state_d  = svm_pkg::S_FIN;
          end
        end else begin
          play_d  = pos[AW-1:0];
          state_d = svm_pkg::S_FIN;
        end
      end
      svm_pkg::S_AMOD: begin
        if (rem_rsp.done) begin
          play_d  = rep_q + rem_rsp.rem;
          state_d = svm_pkg::S_FIN;
        end
      end
      svm_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = svm_pkg::S_IDLE;
        end
      end
      default: state_d = svm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svm_pkg::S_IDLE;
      cnt_q       <= '0;
      play_q      <= '0;
      frac_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      play_q      <= play_d;
      frac_q      <= frac_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    prod_q <= prod_d;
    mixl_q <= mixl_d;
    mixr_q <= mixr_d;
    if (load_out) begin
      outl_q   <= mixl_q;
      outr_q   <= mixr_q;
      outp_q   <= active_q;
      outpos_q <= play_q;
    end
  end

  // Sample store: written on a write transfer, read with a registered output.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[svm_pkg::MEM_AW'(sample_addr_i)] <= sample_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[svm_pkg::MEM_AW'(rd_idx)];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mix_out_left_o  = outl_q;
  assign mix_out_right_o = outr_q;
  assign playing_o       = outp_q;
  assign play_position_o = outpos_q;

  a_rem_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.busy |-> (state_q == svm_pkg::S_EMOD || state_q == svm_pkg::S_AMOD))
    else $error("remainder unit busy outside a fold state");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again before the item finished");

  a_idle_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (play_q == '0))
    else $error("stopped voice holds a nonzero position");

endmodule
`default_nettype wire
